// ===== src/vansc_pkg.sv =====
// shared types and constants for the voronoi area nearest-site counter
// no dependencies; imported by the cell and the top level
package vansc_pkg;

    localparam int BOX_W        = 16;
    localparam int SITE_COUNT_W = 11;
    localparam int IDX_W        = 10;
    localparam int FUNC_W       = 2;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] REG_BOX_X      = 2'd0;
    localparam logic [1:0] REG_BOX_Y      = 2'd1;
    localparam logic [1:0] REG_SITE_COUNT = 2'd2;

    localparam logic [BOX_W-1:0]        BOX_RESET        = 16'd32768;
    localparam logic [SITE_COUNT_W-1:0] SITE_COUNT_RESET = 11'd1;

    typedef struct packed {
        logic valid;
        logic last;
        logic found;
    } vansc_ctl_t;

endpackage

// ===== src/vansc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module vansc_ram #(
    parameter int WIDTH      = 8,
    parameter int DEPTH      = 16,
    parameter int ADDR_WIDTH = 4
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/vansc_cell.sv =====
// one search cell: a bank of site positions, minimum-image distance and best-so-far compare
// depends on vansc_pkg and vansc_ram
module vansc_cell
    import vansc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int ROW_WIDTH   = 8,
    parameter int BANK_DEPTH  = 256,
    parameter int CELL_BITS   = 2,
    parameter int CELL_INDEX  = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [ROW_WIDTH-1:0]              wr_addr,
    input  logic [2*COORD_WIDTH-1:0]          wr_data,
    input  logic signed [COORD_WIDTH-1:0]     pt_x,
    input  logic signed [COORD_WIDTH-1:0]     pt_y,
    input  logic [BOX_W-1:0]                  box_x,
    input  logic [BOX_W-1:0]                  box_y,
    input  logic [CELL_BITS-1:0]              last_col,
    input  vansc_ctl_t                        ctl_in,
    input  logic [ROW_WIDTH-1:0]              row_in,
    input  logic [2*COORD_WIDTH:0]            dist_in,
    input  logic [ROW_WIDTH+CELL_BITS-1:0]    idx_in,
    output vansc_ctl_t                        ctl_out,
    output logic [ROW_WIDTH-1:0]              row_out,
    output logic [2*COORD_WIDTH:0]            dist_out,
    output logic [ROW_WIDTH+CELL_BITS-1:0]    idx_out
);

    localparam int DW     = ((COORD_WIDTH > BOX_W) ? COORD_WIDTH : BOX_W) + 3;
    localparam int DIST_W = 2 * COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int SIDX_W = ROW_WIDTH + CELL_BITS;

    function automatic logic [COORD_WIDTH-1:0] wrap_mag(
        input logic signed [COORD_WIDTH-1:0] site,
        input logic signed [COORD_WIDTH-1:0] pt,
        input logic [BOX_W-1:0]              len
    );
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] two_d;
        logic signed [DW-1:0] l;
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] a;
        d     = DW'(site) - DW'(pt);
        l     = $signed(DW'(len));
        two_d = d <<< 1;
        if (two_d > l) begin
            w = d - l;
        end else if (two_d < -l) begin
            w = d + l;
        end else begin
            w = d;
        end
        a = w[DW-1] ? -w : w;
        return a[COORD_WIDTH-1:0];
    endfunction

    logic [2*COORD_WIDTH-1:0] site_q;
    logic                     act_in;

    vansc_ctl_t             s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, out_ctl_reg;
    logic                   s1_act_reg, s2_act_reg, s3_act_reg;
    logic [ROW_WIDTH-1:0]   s1_row_reg, s2_row_reg, s3_row_reg, out_row_reg;
    logic [DIST_W-1:0]      s1_dist_reg, s2_dist_reg, s3_dist_reg, out_dist_reg;
    logic [SIDX_W-1:0]      s1_idx_reg, s2_idx_reg, s3_idx_reg, out_idx_reg;
    logic [COORD_WIDTH-1:0] mag_x_reg, mag_y_reg;
    logic [SQ_W-1:0]        sq_x_reg, sq_y_reg;

    logic [DIST_W-1:0]      sum;
    logic                   take;
    vansc_ctl_t             out_ctl_next;
    logic [DIST_W-1:0]      out_dist_next;
    logic [SIDX_W-1:0]      out_idx_next;

    vansc_ram #(
        .WIDTH      (2 * COORD_WIDTH),
        .DEPTH      (BANK_DEPTH),
        .ADDR_WIDTH (ROW_WIDTH)
    ) u_bank (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl_in.valid),
        .rd_addr (row_in),
        .rd_data (site_q)
    );

    // sites past the last one in use sit out of the compare
    assign act_in = ctl_in.valid && (!ctl_in.last || (CELL_BITS'(CELL_INDEX) <= last_col));

    always_comb begin
        sum  = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg);
        take = s3_act_reg && (!s3_ctl_reg.found || (sum < s3_dist_reg));
        out_ctl_next       = s3_ctl_reg;
        out_ctl_next.found = s3_ctl_reg.found || take;
        out_dist_next      = take ? sum : s3_dist_reg;
        out_idx_next       = take ? {s3_row_reg, CELL_BITS'(CELL_INDEX)} : s3_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg  <= '0;
            s2_ctl_reg  <= '0;
            s3_ctl_reg  <= '0;
            out_ctl_reg <= '0;
            s1_act_reg  <= 1'b0;
            s2_act_reg  <= 1'b0;
            s3_act_reg  <= 1'b0;
        end else begin
            s1_ctl_reg  <= ctl_in;
            s2_ctl_reg  <= s1_ctl_reg;
            s3_ctl_reg  <= s2_ctl_reg;
            out_ctl_reg <= out_ctl_next;
            s1_act_reg  <= act_in;
            s2_act_reg  <= s1_act_reg;
            s3_act_reg  <= s2_act_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_row_reg   <= row_in;
        s1_dist_reg  <= dist_in;
        s1_idx_reg   <= idx_in;
        s2_row_reg   <= s1_row_reg;
        s2_dist_reg  <= s1_dist_reg;
        s2_idx_reg   <= s1_idx_reg;
        mag_x_reg    <= wrap_mag($signed(site_q[COORD_WIDTH-1:0]), pt_x, box_x);
        mag_y_reg    <= wrap_mag($signed(site_q[2*COORD_WIDTH-1:COORD_WIDTH]), pt_y, box_y);
        s3_row_reg   <= s2_row_reg;
        s3_dist_reg  <= s2_dist_reg;
        s3_idx_reg   <= s2_idx_reg;
        sq_x_reg     <= SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
        sq_y_reg     <= SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);
        out_row_reg  <= s3_row_reg;
        out_dist_reg <= out_dist_next;
        out_idx_reg  <= out_idx_next;
    end

    assign ctl_out  = out_ctl_reg;
    assign row_out  = out_row_reg;
    assign dist_out = out_dist_reg;
    assign idx_out  = out_idx_reg;

endmodule

// ===== src/voronoi_area_nearest_site_counter_core.sv =====
// top level of the voronoi area nearest-site counter: sequencer, chain of search cells,
// hit counter ram, apb registers and output register; depends on vansc_pkg, vansc_cell, vansc_ram
//
// Sites are stored across 2**CELL_BITS cells, site i in cell i mod CELLS at row i / CELLS.
// A sample sends one row token a cycle into the chain; each cell reads its site, forms the
// minimum-image squared distance and keeps the nearer of its own site and the best handed
// on by its neighbour, ties to the lower index. After reset a clearing pass zeroes the hit
// counters, during which no item is taken (registers still accept writes). A load passes
// through ST_DONE, a read through ST_RWAIT and ST_DONE, and a sample issues its rows into
// the chain of four-stage cells, drains it and steps through ST_HREAD, ST_HUPD and ST_DONE.
// A finished result waits in the output register while the next item is taken.
module voronoi_area_nearest_site_counter_core
    import vansc_pkg::*;
#(
    parameter int MAX_SITES   = 1024,
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 24,
    parameter int CELL_BITS   = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [FUNC_W-1:0]             s_func,
    input  logic [IDX_W-1:0]              s_site_index,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [IDX_W-1:0]              m_nearest_index,
    output logic [COUNT_WIDTH-1:0]        m_hit_total
);

    localparam int CELLS      = 1 << CELL_BITS;
    localparam int BANK_DEPTH = (MAX_SITES + CELLS - 1) / CELLS;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int SIDX_W     = ROW_W + CELL_BITS;
    localparam int HIT_AW     = $clog2(MAX_SITES);
    localparam int DIST_W     = 2 * COORD_WIDTH + 1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_ISSUE = 8'b0000_0100,
        ST_DRAIN = 8'b0000_1000,
        ST_HREAD = 8'b0001_0000,
        ST_HUPD  = 8'b0010_0000,
        ST_RWAIT = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [BOX_W-1:0]        box_x_reg, box_y_reg;
    logic [SITE_COUNT_W-1:0] site_count_reg;
    logic                    cfg_wr;

    logic                          s_acc;
    logic [31:0]                   idx_wide;
    logic                          in_table;
    logic [CELL_BITS-1:0]          ld_bank;
    logic [ROW_W-1:0]              ld_row;
    logic                          load_wr;
    logic [CELLS-1:0]              bank_wr_en;

    logic [31:0]                   n_w, nm1_w;
    logic [ROW_W-1:0]              last_row_cfg;
    logic [CELL_BITS-1:0]          last_col_cfg;

    logic signed [COORD_WIDTH-1:0] pt_x_reg, pt_y_reg;
    logic [ROW_W-1:0]              last_row_reg, row_reg;
    logic [CELL_BITS-1:0]          last_col_reg;
    logic                          inside_reg;
    logic [HIT_AW-1:0]             clr_cnt_reg;

    logic                          acc_found_reg;
    logic [DIST_W-1:0]             acc_dist_reg;
    logic [SIDX_W-1:0]             acc_idx_reg;
    logic [31:0]                   acc_idx_wide;

    logic [IDX_W-1:0]              res_idx_reg;
    logic [COUNT_WIDTH-1:0]        res_hits_reg;
    logic                          m_valid_reg;
    logic [IDX_W-1:0]              m_idx_reg;
    logic [COUNT_WIDTH-1:0]        m_hits_reg;

    logic                          hit_wr_en, hit_rd_en;
    logic [HIT_AW-1:0]             hit_wr_addr, hit_rd_addr;
    logic [COUNT_WIDTH-1:0]        hit_wr_data, hit_rd_data, hit_inc;

    vansc_ctl_t                    ch_ctl  [CELLS+1];
    logic [ROW_W-1:0]              ch_row  [CELLS+1];
    logic [DIST_W-1:0]             ch_dist [CELLS+1];
    logic [SIDX_W-1:0]             ch_idx  [CELLS+1];
    logic                          tail_take;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg      <= BOX_RESET;
            box_y_reg      <= BOX_RESET;
            site_count_reg <= SITE_COUNT_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BOX_X:      box_x_reg      <= pwdata[BOX_W-1:0];
                REG_BOX_Y:      box_y_reg      <= pwdata[BOX_W-1:0];
                REG_SITE_COUNT: site_count_reg <= pwdata[SITE_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BOX_X:      prdata = PDATA_W'(box_x_reg);
            REG_BOX_Y:      prdata = PDATA_W'(box_y_reg);
            REG_SITE_COUNT: prdata = PDATA_W'(site_count_reg);
            default:        prdata = '0;
        endcase
    end

    // item decode
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign idx_wide = 32'(s_site_index);
    assign in_table = idx_wide < 32'(MAX_SITES);
    assign ld_bank  = idx_wide[CELL_BITS-1:0];
    assign ld_row   = ROW_W'(idx_wide >> CELL_BITS);
    assign load_wr  = s_acc && (s_func == FUNC_LOAD) && in_table;

    always_comb begin
        for (int j = 0; j < CELLS; j++) begin
            bank_wr_en[j] = load_wr && (ld_bank == CELL_BITS'(j));
        end
    end

    // sites in use, clamped to one through MAX_SITES
    always_comb begin
        n_w = 32'(site_count_reg);
        if (n_w == 32'd0) begin
            n_w = 32'd1;
        end
        if (n_w > 32'(MAX_SITES)) begin
            n_w = 32'(MAX_SITES);
        end
        nm1_w        = n_w - 32'd1;
        last_row_cfg = ROW_W'(nm1_w >> CELL_BITS);
        last_col_cfg = nm1_w[CELL_BITS-1:0];
    end

    // chain of cells
    always_comb begin
        ch_ctl[0].valid = (state_reg == ST_ISSUE);
        ch_ctl[0].last  = (row_reg == last_row_reg);
        ch_ctl[0].found = 1'b0;
        ch_row[0]       = row_reg;
        ch_dist[0]      = '0;
        ch_idx[0]       = '0;
    end

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        vansc_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .ROW_WIDTH   (ROW_W),
            .BANK_DEPTH  (BANK_DEPTH),
            .CELL_BITS   (CELL_BITS),
            .CELL_INDEX  (j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (bank_wr_en[j]),
            .wr_addr  (ld_row),
            .wr_data  ({s_pos_y, s_pos_x}),
            .pt_x     (pt_x_reg),
            .pt_y     (pt_y_reg),
            .box_x    (box_x_reg),
            .box_y    (box_y_reg),
            .last_col (last_col_reg),
            .ctl_in   (ch_ctl[j]),
            .row_in   (ch_row[j]),
            .dist_in  (ch_dist[j]),
            .idx_in   (ch_idx[j]),
            .ctl_out  (ch_ctl[j+1]),
            .row_out  (ch_row[j+1]),
            .dist_out (ch_dist[j+1]),
            .idx_out  (ch_idx[j+1])
        );
    end

    // rows leave the chain in order, so strict less keeps the lowest index
    assign tail_take = ch_ctl[CELLS].valid && ch_ctl[CELLS].found
                       && (!acc_found_reg || (ch_dist[CELLS] < acc_dist_reg));
    assign acc_idx_wide = 32'(acc_idx_reg);

    // hit counter ram
    vansc_ram #(
        .WIDTH      (COUNT_WIDTH),
        .DEPTH      (MAX_SITES),
        .ADDR_WIDTH (HIT_AW)
    ) u_hits (
        .aclk    (aclk),
        .wr_en   (hit_wr_en),
        .wr_addr (hit_wr_addr),
        .wr_data (hit_wr_data),
        .rd_en   (hit_rd_en),
        .rd_addr (hit_rd_addr),
        .rd_data (hit_rd_data)
    );

    assign hit_inc = (hit_rd_data == {COUNT_WIDTH{1'b1}}) ? hit_rd_data
                                                          : hit_rd_data + COUNT_WIDTH'(1);

    always_comb begin
        hit_wr_en   = 1'b0;
        hit_wr_addr = HIT_AW'(idx_wide);
        hit_wr_data = '0;
        hit_rd_en   = 1'b0;
        hit_rd_addr = HIT_AW'(idx_wide);
        case (state_reg)
            ST_CLEAR: begin
                hit_wr_en   = 1'b1;
                hit_wr_addr = clr_cnt_reg;
            end
            ST_IDLE: begin
                hit_wr_en = load_wr;
                hit_rd_en = s_acc && (s_func == FUNC_READ) && in_table;
            end
            ST_HREAD: begin
                hit_rd_en   = 1'b1;
                hit_rd_addr = acc_idx_reg[HIT_AW-1:0];
            end
            ST_HUPD: begin
                hit_wr_en   = 1'b1;
                hit_wr_addr = acc_idx_reg[HIT_AW-1:0];
                hit_wr_data = hit_inc;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == HIT_AW'(MAX_SITES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        FUNC_SAMPLE: state_next = ST_ISSUE;
                        FUNC_READ:   state_next = ST_RWAIT;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (row_reg == last_row_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (ch_ctl[CELLS].valid && ch_ctl[CELLS].last) begin
                    state_next = ST_HREAD;
                end
            end
            ST_HREAD: state_next = ST_HUPD;
            ST_HUPD:  state_next = ST_DONE;
            ST_RWAIT: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            acc_found_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + HIT_AW'(1);
            end
            if (s_acc) begin
                acc_found_reg <= 1'b0;
            end else if (tail_take) begin
                acc_found_reg <= 1'b1;
            end
            if ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pt_x_reg     <= s_pos_x;
            pt_y_reg     <= s_pos_y;
            last_row_reg <= last_row_cfg;
            last_col_reg <= last_col_cfg;
            row_reg      <= '0;
            inside_reg   <= in_table;
            res_idx_reg  <= s_site_index;
            res_hits_reg <= '0;
        end
        if ((state_reg == ST_ISSUE) && (row_reg != last_row_reg)) begin
            row_reg <= row_reg + ROW_W'(1);
        end
        if (tail_take) begin
            acc_dist_reg <= ch_dist[CELLS];
            acc_idx_reg  <= ch_idx[CELLS];
        end
        if (state_reg == ST_RWAIT) begin
            res_hits_reg <= inside_reg ? hit_rd_data : '0;
        end
        if (state_reg == ST_HUPD) begin
            res_idx_reg  <= acc_idx_wide[IDX_W-1:0];
            res_hits_reg <= hit_inc;
        end
        if ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) begin
            m_idx_reg  <= res_idx_reg;
            m_hits_reg <= res_hits_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nearest_index = m_idx_reg;
    assign m_hit_total     = m_hits_reg;

`ifndef NO_ASSERTIONS
    a_hit_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(hit_wr_en && hit_rd_en))
        else $error("hit counter ram read and written in one cycle");

    a_chain_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ch_ctl[CELLS].valid |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("search token left the chain outside a search");

    a_best_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HREAD) |-> acc_found_reg)
        else $error("search finished without a nearest site");
`endif

endmodule
